>>> design/pmrt_pkg.sv
// Shared types and constants for the packed message record to text unit.
// Holds the front-to-back command format, status codes and label text.
// No dependencies.
package pmrt_pkg;

	// Default record layout
	localparam int HEADER_BYTES_DEF = 14;
	localparam int FIELD_COUNT_DEF  = 5;

	// Widths of the fixed fields
	localparam int BYTE_W  = 8;
	localparam int CODE_W  = 3;
	localparam int COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

	// Configuration register indexes
	localparam logic REG_CHECK_EN     = 1'b0;
	localparam logic REG_EXPECTED_LEN = 1'b1;

	// Status codes
	localparam logic [CODE_W-1:0] ST_OK       = 3'd0;
	localparam logic [CODE_W-1:0] ST_SHORT    = 3'd1;
	localparam logic [CODE_W-1:0] ST_UNTERM   = 3'd2;
	localparam logic [CODE_W-1:0] ST_TRAIL    = 3'd3;
	localparam logic [CODE_W-1:0] ST_MISMATCH = 3'd4;

	// Label text, first character in the top byte
	localparam int LABEL_COUNT = 4;
	localparam int LABEL_LEN   = 10;
	localparam logic [8*LABEL_LEN-1:0] LABEL_TEXT [LABEL_COUNT] = '{
		"Date    = ",
		"To      = ",
		"From    = ",
		"Subject = "
	};

	// Item slots within one command, in emission order
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] POS_FIRST   = 4'd0;
	localparam logic [POS_W-1:0] POS_CR2     = 4'd1;
	localparam logic [POS_W-1:0] POS_LBL0    = 4'd2;
	localparam logic [POS_W-1:0] POS_LBL_END = 4'd11;
	localparam logic [POS_W-1:0] POS_STATUS  = 4'd12;
	localparam logic [POS_W-1:0] POS_NONE    = 4'd13;

	// One classified input item: what the back has to emit for it
	typedef struct packed {
		logic              first;     // emit data (text byte or CR)
		logic [BYTE_W-1:0] data;
		logic              cr2;       // second CR (blank line before body)
		logic              lbl;       // emit a label
		logic [1:0]        lbl_idx;
		logic              status;    // end-of-record status item
		logic [CODE_W-1:0] pre_code;  // code known at the front
	} cmd_t;

	// Character pos (0..9) of label idx
	function automatic logic [BYTE_W-1:0] label_char(input logic [1:0] idx,
			input logic [POS_W-1:0] pos);
		logic [8*LABEL_LEN-1:0] word;
		word = LABEL_TEXT[idx] >> (BYTE_W * (LABEL_LEN - 1 - int'(pos)));
		return word[BYTE_W-1:0];
	endfunction

endpackage

>>> design/pmrt_front.sv
// Front part: accepts record bytes, tracks header/field position and
// turns each byte that yields output into one command for the back. Depends on pmrt_pkg.
module pmrt_front
	import pmrt_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int FIELD_COUNT  = FIELD_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] in_data,
	input  logic              in_last,
	input  logic              q_full,
	output logic              in_ready,
	output logic              push,
	output cmd_t              push_cmd
);

	localparam int HCW = $clog2(HEADER_BYTES + 1);
	localparam int FIW = $clog2(FIELD_COUNT);
	localparam logic [HCW-1:0] HB_LAST  = HCW'(HEADER_BYTES - 1);
	localparam logic [FIW-1:0] FI_BODY  = FIW'(FIELD_COUNT - 1);
	localparam logic [FIW-1:0] FI_PENUL = FIW'(FIELD_COUNT - 2);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_FIELDS,
		PH_DONE
	} phase_t;

	phase_t         phase_q, phase_n;
	logic [HCW-1:0] hcnt_q, hcnt_n;
	logic [FIW-1:0] fidx_q, fidx_n;
	logic           trail_q, trail_n;
	logic           accept;
	cmd_t           cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push_cmd = cmd;
	assign push     = accept && (cmd.first || cmd.lbl || cmd.status);

	// Classify the byte and work out the next record position
	always_comb begin
		cmd     = '0;
		phase_n = phase_q;
		hcnt_n  = hcnt_q;
		fidx_n  = fidx_q;
		trail_n = trail_q;
		case (phase_q)
			PH_HEADER: begin
				if (hcnt_q == HB_LAST) begin
					phase_n     = PH_FIELDS;
					fidx_n      = '0;
					cmd.lbl     = 1'b1;
					cmd.lbl_idx = 2'd0;
				end else begin
					hcnt_n = hcnt_q + 1'b1;
				end
			end
			PH_FIELDS: begin
				cmd.first = 1'b1;
				if (in_data != '0) begin
					cmd.data = in_data;
				end else begin
					cmd.data = CR_BYTE;
					cmd.cr2  = (fidx_q == FI_PENUL);
					if (fidx_q == FI_BODY) begin
						phase_n = PH_DONE;
					end else begin
						fidx_n      = fidx_q + 1'b1;
						// fields past the fourth carry no label
						cmd.lbl     = (fidx_n != FI_BODY) && (int'(fidx_n) < LABEL_COUNT);
						cmd.lbl_idx = 2'(fidx_n);
					end
				end
			end
			PH_DONE: begin
				trail_n = 1'b1;
			end
			default: begin
				phase_n = PH_HEADER;
			end
		endcase

		// Record end: attach status and drop back to the start
		if (in_last) begin
			cmd.status = 1'b1;
			if (phase_n == PH_HEADER)
				cmd.pre_code = ST_SHORT;
			else if (phase_n == PH_FIELDS)
				cmd.pre_code = ST_UNTERM;
			else if (trail_n)
				cmd.pre_code = ST_TRAIL;
			else
				cmd.pre_code = ST_OK;
			phase_n = PH_HEADER;
			hcnt_n  = '0;
			fidx_n  = '0;
			trail_n = 1'b0;
		end
	end

	// Hold record position; advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hcnt_q  <= '0;
			fidx_q  <= '0;
			trail_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			hcnt_q  <= hcnt_n;
			fidx_q  <= fidx_n;
			trail_q <= trail_n;
		end
	end

endmodule

>>> design/pmrt_queue.sv
// Short command queue between front and back parts.
// Depends on pmrt_pkg for the command type.
module pmrt_queue
	import pmrt_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == DEPTH_C);
	assign head  = mem_q[rptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_cmd;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> design/pmrt_back.sv
// Back part: walks each queued command item by item, keeps the rendered
// length and drives the output register. Depends on pmrt_pkg.
module pmrt_back
	import pmrt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  cmd_t               head,
	input  logic               check_en,
	input  logic [COUNT_W-1:0] expected_len,
	input  logic               out_ready,
	output logic               pop,
	output logic               out_valid,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               is_status,
	output logic [CODE_W-1:0]  status_code,
	output logic [COUNT_W-1:0] rendered_length,
	output logic               out_last
);

	logic [POS_W-1:0]   pos_q, cur, nxt, lbl_pos;
	logic [COUNT_W-1:0] cnt_q, cnt_inc;
	logic               ov_q, advance, fire, cur_status;
	logic [BYTE_W-1:0]  item_byte;
	logic [CODE_W-1:0]  item_code;

	// First slot at or after p that this command fills
	function automatic logic [POS_W-1:0] first_present(input cmd_t c,
			input logic [POS_W-1:0] p);
		logic [POS_W-1:0] r;
		if (p == POS_FIRST && c.first)
			r = POS_FIRST;
		else if (p <= POS_CR2 && c.cr2)
			r = POS_CR2;
		else if (p <= POS_LBL_END && c.lbl)
			r = (p < POS_LBL0) ? POS_LBL0 : p;
		else if (p <= POS_STATUS && c.status)
			r = POS_STATUS;
		else
			r = POS_NONE;
		return r;
	endfunction

	assign advance    = !ov_q || out_ready;
	assign fire       = !empty && advance;
	assign cur        = first_present(head, pos_q);
	assign nxt        = first_present(head, cur + 1'b1);
	assign pop        = fire && (nxt == POS_NONE);
	assign cur_status = (cur == POS_STATUS);
	assign lbl_pos    = cur - POS_LBL0;
	assign cnt_inc    = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

	// Select the byte of the current slot
	always_comb begin
		if (cur == POS_FIRST)
			item_byte = head.data;
		else if (cur == POS_CR2)
			item_byte = CR_BYTE;
		else if (cur_status)
			item_byte = '0;
		else
			item_byte = label_char(head.lbl_idx, lbl_pos);
	end

	// Final status: length check only when nothing else went wrong
	always_comb begin
		if (head.pre_code != ST_OK)
			item_code = head.pre_code;
		else if (check_en && (cnt_q != expected_len))
			item_code = ST_MISMATCH;
		else
			item_code = ST_OK;
	end

	// Step through slots; count text bytes; clear count after status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FIRST;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (advance)
				ov_q <= fire;
			if (fire) begin
				pos_q <= (nxt == POS_NONE) ? POS_FIRST : nxt;
				cnt_q <= cur_status ? '0 : cnt_inc;
			end
		end
	end

	// Load output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte        <= item_byte;
			is_status       <= cur_status;
			status_code     <= cur_status ? item_code : ST_OK;
			rendered_length <= cur_status ? cnt_q : cnt_inc;
			out_last        <= cur_status;
		end
	end

	assign out_valid = ov_q;

endmodule

>>> design/packed_message_record_to_text_unit.sv
// Packed message record to text unit: top level.
// Uses pmrt_pkg, pmrt_front, pmrt_queue and pmrt_back.
//
// Input channel (s_*): one record byte per item, s_tlast on the record's
// final byte. The first HEADER_BYTES bytes are skipped; the rest is split
// into FIELD_COUNT NUL-terminated fields.
// Output channel (m_*): rendered text bytes (labels, field text, CRs),
// then one status item per record with m_tuser set and m_tlast high. It
// carries the status code and the rendered length; text items carry the
// running length. On a nonzero code the consumer drops the record's text.
// Config port: cfg_we writes register cfg_index (0 length check enable,
// 1 expected length) with cfg_data; write only while the unit is idle.
// The first result of an accepted byte passes the command queue and the back's
// output register. The back emits one result item per cycle unless the queue
// is empty or m_tready stalls it. A plain text byte gives one item; a NUL that
// opens a labeled field gives eleven (CR and ten label characters), twelve with
// the status item on a record's last byte. A four-entry queue lets input run ahead.
// Reset clears record position, queue, rendered length and output valid;
// config registers return to zero. When m_tready is low the output item
// holds, the queue fills and s_tready drops once it is full.
module packed_message_record_to_text_unit
	import pmrt_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int FIELD_COUNT  = FIELD_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] in_byte
	input  logic               s_tlast,   // in_last
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,   // [7:0] out_byte, [10:8] status_code,
	                                      // [27:11] rendered_length, [31:28] zero
	output logic [0:0]         m_tuser,   // [0] is_status
	output logic               m_tlast,   // last
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [COUNT_W-1:0] cfg_data
);

	logic               check_en_q;
	logic [COUNT_W-1:0] expected_q;
	logic               push, pop, q_empty, q_full;
	cmd_t               push_cmd, head;
	logic [BYTE_W-1:0]  out_byte;
	logic               is_status;
	logic [CODE_W-1:0]  status_code;
	logic [COUNT_W-1:0] rendered_length;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_en_q <= 1'b0;
			expected_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_CHECK_EN)
				check_en_q <= cfg_data[0];
			else
				expected_q <= cfg_data;
		end
	end

	pmrt_front #(
		.HEADER_BYTES(HEADER_BYTES),
		.FIELD_COUNT (FIELD_COUNT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_data (s_tdata),
		.in_last (s_tlast),
		.q_full  (q_full),
		.in_ready(s_tready),
		.push    (push),
		.push_cmd(push_cmd)
	);

	pmrt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	pmrt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (q_empty),
		.head           (head),
		.check_en       (check_en_q),
		.expected_len   (expected_q),
		.out_ready      (m_tready),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_byte       (out_byte),
		.is_status      (is_status),
		.status_code    (status_code),
		.rendered_length(rendered_length),
		.out_last       (m_tlast)
	);

	// Pack output fields
	assign m_tdata = {4'b0000, rendered_length, status_code, out_byte};
	assign m_tuser = is_status;

endmodule

>>> design/pmrt_checker.sv
// Port-level checker for the packed message record to text unit, with the
// bind that attaches it to the top level. Depends on pmrt_pkg for status codes.
module pmrt_checker
	import pmrt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// Stalled output item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output item changed while stalled");

	// Status items close the record, text items never do
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser[0]))
		else $error("tlast does not match status flag");

	// Status item carries no byte and a known code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[7:0] == 8'h00) && (m_tdata[10:8] <= ST_MISMATCH))
		else $error("bad status item");

	// Text items carry no code and a nonzero running length
	a_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[10:8] == ST_OK) && (m_tdata[27:11] != 17'd0))
		else $error("bad text item");

endmodule

bind packed_message_record_to_text_unit pmrt_checker u_pmrt_checker (.*);

>>> tb/tb_top.sv
// Testbench for packed_message_record_to_text_unit: streams message records
// through the unit and checks every text and status item against a predictor.
// Depends on pmrt_pkg and the unit's RTL only.
module tb_top;
	import pmrt_pkg::*;

	localparam int HDR_LEN      = HEADER_BYTES_DEF;
	localparam int NUM_FIELDS   = FIELD_COUNT_DEF;
	localparam int HOLD_CYCLES  = 200;
	localparam int QUIET_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 16;
	localparam int PHASE_ITEMS  = 25;

	// Field labels, first character in the top byte
	localparam logic [79:0] LINE_TAGS [4] = '{
		"Date    = ",
		"To      = ",
		"From    = ",
		"Subject = "
	};

	typedef enum int {
		MODE_STEADY,
		MODE_SEND_GAPS,
		MODE_RECV_STALLS,
		MODE_BOTH_IDLE,
		MODE_RECV_HOLD
	} idle_mode_t;

	typedef enum int {REC_GOOD, REC_TRAIL, REC_CUT, REC_SHORT} rec_kind_t;

	typedef enum logic [1:0] {PH_HEADER, PH_FIELDS, PH_DONE} rec_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       ends;
	} record_byte_t;

	typedef struct packed {
		logic [7:0]         ch;
		logic               stat;
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] len;
		logic               lst;
	} text_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [31:0]        m_tdata;
	logic [0:0]         m_tuser;
	logic               m_tlast;
	logic               cfg_we = 1'b0;
	logic               cfg_index = 1'b0;
	logic [COUNT_W-1:0] cfg_data = '0;

	// Pending input items and expected result items
	record_byte_t send_q[$];
	logic [7:0]   stage_q[$];
	text_item_t   rendered_q[$];

	idle_mode_t idle_mode = MODE_STEADY;
	int         hold_cnt = 0;
	int         quiet_cycles = 0;
	int         pushed_n = 0;
	int         accepted_n = 0;
	int         predicted_n = 0;
	int         matched_n = 0;
	int         results_n = 0;
	int         records_done = 0;
	int         err_count = 0;

	// Predictor copy of the registers and the record state
	logic               check_on = 1'b0;
	logic [COUNT_W-1:0] want_len = '0;
	rec_phase_t         rec_phase = PH_HEADER;
	int                 hdr_seen = 0;
	int                 field_no = 0;
	logic [COUNT_W-1:0] text_len = '0;
	logic               trail_seen = 1'b0;

	packed_message_record_to_text_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		err_count++;
		if (err_count <= 40) begin
			$display("MISMATCH: %s", msg);
		end
	endtask

	function automatic int idle_pct(input idle_mode_t m, input logic rx);
		case (m)
			MODE_SEND_GAPS:   return rx ? 0 : 74;
			MODE_RECV_STALLS: return rx ? 74 : 0;
			MODE_BOTH_IDLE:   return 13;
			default:          return 0;
		endcase
	endfunction

	// Append one text item, saturating the running length
	task automatic put_text(input logic [7:0] ch);
		if (text_len != COUNT_MAX) begin
			text_len++;
		end
		rendered_q.push_back('{ch, 1'b0, ST_OK, text_len, 1'b0});
		predicted_n++;
	endtask

	task automatic put_label(input int idx);
		if (idx < NUM_FIELDS - 1 && idx < 4) begin
			for (int i = 0; i < 10; i++) begin
				put_text(LINE_TAGS[idx][8*(9-i) +: 8]);
			end
		end
	endtask

	// Work out the items that one accepted record byte causes
	task automatic render_byte(input logic [7:0] b, input logic l);
		logic [CODE_W-1:0] code;
		if (rec_phase == PH_HEADER) begin
			hdr_seen++;
			if (hdr_seen >= HDR_LEN) begin
				rec_phase = PH_FIELDS;
				field_no = 0;
				put_label(0);
			end
		end else if (rec_phase == PH_FIELDS) begin
			if (b != 8'h00) begin
				put_text(b);
			end else begin
				put_text(CR_BYTE);
				// blank line between subject and body
				if (field_no == NUM_FIELDS - 2) begin
					put_text(CR_BYTE);
				end
				if (field_no >= NUM_FIELDS - 1) begin
					rec_phase = PH_DONE;
				end else begin
					field_no++;
					put_label(field_no);
				end
			end
		end else begin
			trail_seen = 1'b1;
		end

		if (l) begin
			if (rec_phase == PH_HEADER) begin
				code = ST_SHORT;
			end else if (rec_phase == PH_FIELDS) begin
				code = ST_UNTERM;
			end else if (trail_seen) begin
				code = ST_TRAIL;
			end else if (check_on && text_len != want_len) begin
				code = ST_MISMATCH;
			end else begin
				code = ST_OK;
			end
			rendered_q.push_back('{8'h00, 1'b1, code, text_len, 1'b1});
			predicted_n++;
			records_done++;
			rec_phase = PH_HEADER;
			hdr_seen = 0;
			field_no = 0;
			text_len = '0;
			trail_seen = 1'b0;
		end
	endtask

	// Driver: offer the oldest pending item, hold it until taken
	always @(posedge clk) begin : feed_in
		logic gap;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				render_byte(s_tdata, s_tlast);
				void'(send_q.pop_front());
				accepted_n++;
			end
			if (!(s_tvalid && !s_tready)) begin
				gap = ($urandom_range(99) < idle_pct(idle_mode, 1'b0));
				if (send_q.size() != 0 && !gap) begin
					s_tvalid <= 1'b1;
					s_tdata  <= send_q[0].data;
					s_tlast  <= send_q[0].ends;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver pacing: random stalls, or one long hold-off counted here
	always @(posedge clk) begin : pace_out
		if (idle_mode == MODE_RECV_HOLD) begin
			if (hold_cnt < HOLD_CYCLES) begin
				hold_cnt <= hold_cnt + 1;
			end
		end else begin
			hold_cnt <= 0;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (idle_mode == MODE_RECV_HOLD) begin
			m_tready <= (hold_cnt >= HOLD_CYCLES);
		end else begin
			m_tready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b1));
		end
	end

	// Monitor: compare each accepted result item with the oldest expectation
	always @(posedge clk) begin : watch_out
		text_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_n++;
			if (rendered_q.size() == 0) begin
				report_error($sformatf("result with nothing expected, tdata %h", m_tdata));
			end else begin
				want = rendered_q.pop_front();
				matched_n++;
				if (m_tdata[7:0] != want.ch)
					report_error($sformatf("item %0d out_byte %h, want %h",
						results_n, m_tdata[7:0], want.ch));
				if (m_tuser[0] != want.stat)
					report_error($sformatf("item %0d is_status %b, want %b",
						results_n, m_tuser[0], want.stat));
				if (m_tdata[10:8] != want.code)
					report_error($sformatf("item %0d status_code %0d, want %0d",
						results_n, m_tdata[10:8], want.code));
				if (m_tdata[27:11] != want.len)
					report_error($sformatf("item %0d rendered_length %0d, want %0d",
						results_n, m_tdata[27:11], want.len));
				if (m_tlast != want.lst)
					report_error($sformatf("item %0d last %b, want %b",
						results_n, m_tlast, want.lst));
				if (m_tdata[31:28] != 4'h0)
					report_error($sformatf("item %0d pad bits %h", results_n, m_tdata[31:28]));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TIMEOUT: no item moved for %0d cycles", QUIET_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CHECK_EN) begin
			check_on = val[0];
		end else begin
			want_len = val;
		end
	endtask

	// Hold the sender until every expected item has come, then let the unit settle
	task automatic wait_drained();
		wait (accepted_n == pushed_n);
		wait (matched_n == predicted_n);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Move the staged record into the pending queue, last mark on its final byte
	task automatic send_staged();
		for (int i = 0; i < stage_q.size(); i++) begin
			send_q.push_back('{stage_q[i], i == stage_q.size() - 1});
		end
		pushed_n += stage_q.size();
		stage_q.delete();
	endtask

	// Stage one record of the given kind; return its rendered length if complete
	task automatic build_record(input rec_kind_t kind, input int max_len,
			output int rec_len);
		int n;
		int keep;
		rec_len = 0;
		if (kind == REC_SHORT) begin
			n = $urandom_range(HDR_LEN - 1, 1);
			repeat (n) stage_q.push_back(8'($urandom));
		end else begin
			repeat (HDR_LEN) stage_q.push_back(8'($urandom));
			// four labels, a CR per field, one blank line
			rec_len = 4 * 10 + NUM_FIELDS + 1;
			for (int f = 0; f < NUM_FIELDS; f++) begin
				n = $urandom_range(max_len, 0);
				rec_len += n;
				repeat (n) stage_q.push_back(8'($urandom_range(255, 1)));
				stage_q.push_back(8'h00);
			end
			if (kind == REC_TRAIL) begin
				repeat ($urandom_range(3, 1)) stage_q.push_back(8'($urandom));
			end
			// drop the tail so the body or an earlier field is left open
			if (kind == REC_CUT) begin
				keep = $urandom_range(stage_q.size() - 1, HDR_LEN);
				while (stage_q.size() > keep) void'(stage_q.pop_back());
			end
		end
	endtask

	task automatic run_random_phase(input idle_mode_t m, input logic en,
			input logic [COUNT_W-1:0] lim);
		int start;
		int pick;
		int rec_len;
		rec_kind_t kind;
		write_reg(REG_CHECK_EN, en);
		write_reg(REG_EXPECTED_LEN, lim);
		idle_mode = m;
		start = pushed_n;
		while (pushed_n - start < PHASE_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 70) kind = REC_GOOD;
			else if (pick < 80) kind = REC_TRAIL;
			else if (pick < 90) kind = REC_CUT;
			else kind = REC_SHORT;
			build_record(kind, 6, rec_len);
			send_staged();
		end
		wait_drained();
	endtask

	initial begin : stimulus
		int rec_len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(REG_CHECK_EN, 1'b0);
		write_reg(REG_EXPECTED_LEN, '0);

		// Directed: a one-byte record ends inside the header
		idle_mode = MODE_STEADY;
		stage_q.push_back(8'hFF);
		send_staged();
		// Directed: header of extreme bytes, extreme field bytes, empty fields,
		// then a byte after the body terminator
		for (int i = 0; i < HDR_LEN; i++) stage_q.push_back(i % 2 ? 8'hFF : 8'h00);
		stage_q.push_back(8'h01);
		stage_q.push_back(8'h00);
		stage_q.push_back(8'h00);
		stage_q.push_back(8'h00);
		stage_q.push_back(8'hFF);
		stage_q.push_back(8'h00);
		stage_q.push_back(8'h00);
		stage_q.push_back(8'h80);
		send_staged();
		wait_drained();

		// Random records under steady, sender-gap, receiver-stall and mixed idling, varied registers
		run_random_phase(MODE_STEADY, 1'b0, COUNT_MAX);
		run_random_phase(MODE_SEND_GAPS, 1'b1, COUNT_MAX);
		run_random_phase(MODE_RECV_STALLS, 1'b1, '0);
		run_random_phase(MODE_BOTH_IDLE, 1'b0, '0);

		// Long receiver hold-off while the sender keeps offering
		idle_mode = MODE_RECV_HOLD;
		build_record(REC_GOOD, 12, rec_len);
		send_staged();
		wait_drained();

		// Length check: exact, one over, one under
		idle_mode = MODE_BOTH_IDLE;
		for (int i = 0; i < 3; i++) begin
			build_record(REC_GOOD, 4, rec_len);
			write_reg(REG_CHECK_EN, 1'b1);
			write_reg(REG_EXPECTED_LEN, COUNT_W'(i == 0 ? rec_len :
				(i == 1 ? rec_len + 1 : rec_len - 1)));
			send_staged();
			wait_drained();
		end

		if (rendered_q.size() != 0) begin
			report_error($sformatf("%0d expected items never arrived", rendered_q.size()));
		end
		$display("Covered %0d records (%0d bytes in, %0d items out) under steady,",
			records_done, accepted_n, results_n);
		$display("sender-gap, receiver-stall, mixed and long back-pressure pacing.");
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
